[src/bounded_array_list_core_macros.svh]
// ----------------------------------------------------------------------------
// bounded_array_list_core_macros.svh
// Assertion shorthands for the bounded array list core.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_CORE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BAL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bal_pkg.sv]
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants of the bounded array list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 9;
  localparam int OP_W   = 3;

  // Capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET  = 9'd256;
  // found_at code for "no match" (-1 in 9 bits)
  localparam logic [CNT_W-1:0] FOUND_NONE = 9'h1FF;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_PREPEND = 3'd2,
    OP_POP     = 3'd3,
    OP_READ    = 3'd4,
    OP_FIND    = 3'd5,
    OP_DELETE  = 3'd6,
    OP_REMOVE  = 3'd7
  } op_t;

  // One request word
  typedef struct packed {
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  val;
  } req_t;

  // One result word
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [CNT_W-1:0]   found_at;
    logic               status;
    logic [CNT_W-1:0]   entries;
  } res_t;

endpackage

`default_nettype wire

[src/bal_store.sv]
// ----------------------------------------------------------------------------
// bal_store
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bal_store #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [bal_pkg::DATA_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [bal_pkg::DATA_W-1:0] rdata
);
  import bal_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered: data follows in the cycle after the address
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/bal_ctrl.sv]
// ----------------------------------------------------------------------------
// bal_ctrl
// Request sequencer: walks the store one entry per cycle through a shared
// compare and index step for shifts, searches and compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_array_list_core_macros.svh"

module bal_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [bal_pkg::CNT_W-1:0]  capacity,
  // request side
  input  wire logic                       req_valid,
  input  wire bal_pkg::req_t              req,
  output logic                            req_ready,
  // result side
  output logic                            res_valid,
  output bal_pkg::res_t                   res,
  input  wire logic                       res_take,
  // store port
  output logic                            mem_we,
  output logic      [AW-1:0]              mem_waddr,
  output logic      [bal_pkg::DATA_W-1:0] mem_wdata,
  output logic                            mem_re,
  output logic      [AW-1:0]              mem_raddr,
  input  wire logic [bal_pkg::DATA_W-1:0] mem_rdata
);
  import bal_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_PUT,
    ST_RDWAIT,
    ST_FINISH
  } state_t;

  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  // List index to store address (zero-extend or trim)
  function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] idx);
    logic [CNT_W+AW-1:0] wide;
    wide = {{AW{1'b0}}, idx};
    return wide[AW-1:0];
  endfunction

  state_t            state, state_next;
  op_t               op, op_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [DATA_W-1:0] val, val_next;
  logic [CNT_W-1:0]  rp, rp_next;       // next index to read
  logic [CNT_W-1:0]  pi, pi_next;       // index of the word in flight
  logic [CNT_W-1:0]  wp, wp_next;       // compaction write index
  logic              pend, pend_next;   // read data returns this cycle
  logic              issuing, issuing_next;
  logic              hit, hit_next;
  logic [DATA_W-1:0] data, data_next;
  logic [CNT_W-1:0]  found, found_next;
  logic              refused, refused_next;
  logic [CNT_W-1:0]  count, count_next;

  logic [CNT_W-1:0]  ins_pos;
  logic [CNT_W-1:0]  pos_ext;
  logic              room;
  logic              count_fits;
  logic              cmp_eq;
  logic              walk_down;

  // Shared step: compare and limit checks
  assign pos_ext    = {1'b0, pos};
  assign ins_pos    = (op == OP_PREPEND) ? '0 : pos_ext;
  assign count_fits = {{(32-CNT_W){1'b0}}, count} < 32'(DEPTH);
  assign room       = (count < capacity) && count_fits;
  assign cmp_eq     = (mem_rdata == val);
  assign walk_down  = (op == OP_INSERT) || (op == OP_PREPEND);

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_FINISH);
  assign res       = '{data: data, found_at: found, status: refused, entries: count};

  // Sequencer next state
  always_comb begin
    state_next   = state;
    op_next      = op;
    pos_next     = pos;
    val_next     = val;
    rp_next      = rp;
    pi_next      = pi;
    wp_next      = wp;
    pend_next    = pend;
    issuing_next = issuing;
    hit_next     = hit;
    data_next    = data;
    found_next   = found;
    refused_next = refused;
    count_next   = count;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = val;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_next      = req.op;
          pos_next     = req.pos;
          val_next     = req.val;
          data_next    = '0;
          found_next   = FOUND_NONE;
          refused_next = 1'b1;
          hit_next     = 1'b0;
          state_next   = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_next = ST_FINISH;
        case (op)
          OP_APPEND: begin
            if (room) begin
              mem_we       = 1'b1;
              mem_waddr    = to_addr(count);
              count_next   = count + ONE;
              refused_next = 1'b0;
            end
          end
          OP_INSERT, OP_PREPEND: begin
            if (room && (ins_pos <= count)) begin
              refused_next = 1'b0;
              if (ins_pos == count) begin
                mem_we     = 1'b1;
                mem_waddr  = to_addr(ins_pos);
                count_next = count + ONE;
              end else begin
                rp_next      = count - ONE;
                issuing_next = 1'b1;
                state_next   = ST_SCAN;
              end
            end
          end
          OP_POP: begin
            if (count != '0) begin
              mem_re       = 1'b1;
              mem_raddr    = to_addr(count - ONE);
              count_next   = count - ONE;
              refused_next = 1'b0;
              state_next   = ST_RDWAIT;
            end
          end
          OP_READ: begin
            if (pos_ext < count) begin
              mem_re       = 1'b1;
              mem_raddr    = to_addr(pos_ext);
              refused_next = 1'b0;
              state_next   = ST_RDWAIT;
            end
          end
          OP_FIND, OP_REMOVE: begin
            if (count != '0) begin
              rp_next      = '0;
              wp_next      = '0;
              issuing_next = 1'b1;
              state_next   = ST_SCAN;
            end
          end
          OP_DELETE: begin
            if (pos_ext < count) begin
              refused_next = 1'b0;
              if (pos_ext + ONE == count) begin
                count_next = count - ONE;
              end else begin
                rp_next      = pos_ext + ONE;
                issuing_next = 1'b1;
                state_next   = ST_SCAN;
              end
            end
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end

      ST_SCAN: begin
        // read side: one entry per cycle
        if (issuing) begin
          mem_re    = 1'b1;
          mem_raddr = to_addr(rp);
          pend_next = 1'b1;
          pi_next   = rp;
          if (walk_down) begin
            if (rp == ins_pos) issuing_next = 1'b0;
            else               rp_next      = rp - ONE;
          end else begin
            if (rp + ONE == count) issuing_next = 1'b0;
            else                   rp_next      = rp + ONE;
          end
        end else begin
          pend_next = 1'b0;
        end

        // return side: move or compare the word read last cycle
        if (pend) begin
          case (op)
            OP_INSERT, OP_PREPEND: begin
              mem_we    = 1'b1;
              mem_waddr = to_addr(pi + ONE);
              mem_wdata = mem_rdata;
            end
            OP_DELETE: begin
              mem_we    = 1'b1;
              mem_waddr = to_addr(pi - ONE);
              mem_wdata = mem_rdata;
            end
            OP_REMOVE: begin
              if (cmp_eq) begin
                hit_next = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = to_addr(wp);
                mem_wdata = mem_rdata;
                wp_next   = wp + ONE;
              end
            end
            OP_FIND: begin
              if (cmp_eq) begin
                hit_next     = 1'b1;
                found_next   = pi;
                issuing_next = 1'b0;
                pend_next    = 1'b0;
              end
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end

        // walk finished
        if (!issuing && !pend) begin
          state_next = ST_FINISH;
          case (op)
            OP_INSERT, OP_PREPEND: state_next = ST_PUT;
            OP_DELETE:             count_next = count - ONE;
            OP_REMOVE: begin
              count_next   = wp;
              refused_next = !hit;
            end
            OP_FIND:               refused_next = !hit;
            default:               state_next = ST_FINISH;
          endcase
        end
      end

      ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = to_addr(ins_pos);
        count_next = count + ONE;
        state_next = ST_FINISH;
      end

      ST_RDWAIT: begin
        data_next  = mem_rdata;
        state_next = ST_FINISH;
      end

      ST_FINISH: begin
        if (res_take) state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      pend    <= 1'b0;
      issuing <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pend    <= pend_next;
      issuing <= issuing_next;
    end
    op      <= op_next;
    pos     <= pos_next;
    val     <= val_next;
    rp      <= rp_next;
    pi      <= pi_next;
    wp      <= wp_next;
    hit     <= hit_next;
    data    <= data_next;
    found   <= found_next;
    refused <= refused_next;
  end

  // Checks
  `BAL_ASSERT_IMPL(a_count_fits, 1'b1, count_fits || ({{(32-CNT_W){1'b0}}, count} == 32'(DEPTH)), "entry count above store depth")
  `BAL_ASSERT_IMPL(a_pend_in_scan, pend, state == ST_SCAN, "read in flight outside a walk")
  `BAL_ASSERT_NEXT(a_idle_count, state == ST_IDLE, $stable(count), "entry count moved while idle")
  `BAL_ASSERT_IMPL(a_found_none, (state == ST_FINISH) && ((op != OP_FIND) || refused), found == FOUND_NONE, "position reported without a find hit")

endmodule

`default_nettype wire

[src/bounded_array_list_core.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_core
// Ordered list of signed 32-bit values in a fixed store, with append,
// insert, prepend, pop, read, find, delete and remove-all requests.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)                    | tuser
//  s_axis    | in  | position[7:0], value[39:8]            | operation[2:0]
//  m_axis    | out | data[31:0], found_at[40:32],          | status[0]
//            |     | entries[49:41], zero[55:50]           |
//  cfg       | in  | cfg_wdata = capacity (9 bits)         | -
//
//  Each request passes IDLE, DECIDE and FINISH; read and pop add a read
//  wait, insert, prepend and delete a walk over the moved entries (insert
//  and prepend then a final write), find and remove-all a walk over the
//  entries scanned. The walk is set by the single store read port.
//  A new word is taken once the previous result sits in the output register.
//  The store needs no clearing pass: reset only empties the count.
//  A stalled m_axis holds its word; the core waits with the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_core #(
  parameter int DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,      // capacity
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
  input  wire logic [2:0]  s_axis_tuser,   // operation[2:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [55:0] m_axis_tdata,   // data, found_at, entries, pad
  output logic      [0:0]  m_axis_tuser    // status[0]
);
  import bal_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CNT_W-1:0]  capacity;
  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              slot_free;
  res_t              out_res;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Request unpacking
  assign req = '{op: op_t'(s_axis_tuser),
                 pos: s_axis_tdata[POS_W-1:0],
                 val: s_axis_tdata[POS_W+DATA_W-1:POS_W]};

  bal_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .req_valid (s_axis_tvalid),
    .req       (req),
    .req_ready (s_axis_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (slot_free),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bal_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && slot_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_valid && slot_free) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'b0, out_res.entries, out_res.found_at, out_res.data};
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded array list core. A mirror of the list
// predicts the result word of every accepted request and checks the result
// stream field by field, in order. A short directed run covers the edge cases
// first. Random phases follow, each at its own capacity, in three idle patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import bal_pkg::*;

  localparam int STORE_DEPTH  = 256;
  localparam int PHASE_COUNT  = 9;
  localparam int PHASE_ITEMS  = 120;
  localparam int HOLD_LEN     = 400;
  localparam int SETTLE_WAIT  = 8;
  localparam int DRAIN_WAIT   = 300;
  localparam int CYCLE_LIMIT  = 3000000;

  // Mirror of the list; predicts and checks result words
  class list_mirror;
    logic [DATA_W-1:0] cells [STORE_DEPTH];
    int                held;
    logic [CNT_W-1:0]  cap_reg;
    res_t              due_results [$];
    int                faults;

    function new();
      foreach (cells[i]) cells[i] = '0;
      held    = 0;
      cap_reg = CAP_RESET;
      faults  = 0;
    endfunction

    // Shift entries pos..held-1 up one and place v at pos
    function void open_gap(int pos, logic [DATA_W-1:0] v);
      for (int i = held; i > pos; i--) cells[i] = cells[i-1];
      cells[pos] = v;
      held++;
    endfunction

    // Shift entries pos+1..held-1 down one
    function void close_gap(int pos);
      for (int i = pos; i + 1 < held; i++) cells[i] = cells[i+1];
      held--;
    endfunction

    // Apply one accepted request and queue its result word
    function void take_request(req_t r);
      res_t e;
      int   lim;
      int   w;
      bit   room;
      bit   hit;
      lim  = (cap_reg < STORE_DEPTH) ? int'(cap_reg) : STORE_DEPTH;
      room = held < lim;
      hit  = 1'b0;
      e.data     = '0;
      e.found_at = FOUND_NONE;
      e.status   = 1'b1;
      case (r.op)
        OP_APPEND: begin
          if (room) begin
            open_gap(held, r.val);
            e.status = 1'b0;
          end
        end
        OP_INSERT: begin
          if (room && int'(r.pos) <= held) begin
            open_gap(int'(r.pos), r.val);
            e.status = 1'b0;
          end
        end
        OP_PREPEND: begin
          if (room) begin
            open_gap(0, r.val);
            e.status = 1'b0;
          end
        end
        OP_POP: begin
          if (held > 0) begin
            e.data = cells[held-1];
            held--;
            e.status = 1'b0;
          end
        end
        OP_READ: begin
          if (int'(r.pos) < held) begin
            e.data   = cells[r.pos];
            e.status = 1'b0;
          end
        end
        OP_FIND: begin
          for (int i = 0; i < held; i++) begin
            if (!hit && cells[i] == r.val) begin
              hit        = 1'b1;
              e.found_at = i[CNT_W-1:0];
              e.status   = 1'b0;
            end
          end
        end
        OP_DELETE: begin
          if (int'(r.pos) < held) begin
            close_gap(int'(r.pos));
            e.status = 1'b0;
          end
        end
        default: begin
          // remove all: compact survivors in order
          w = 0;
          for (int i = 0; i < held; i++) begin
            if (cells[i] == r.val) e.status = 1'b0;
            else begin
              cells[w] = cells[i];
              w++;
            end
          end
          held = w;
        end
      endcase
      e.entries = held[CNT_W-1:0];
      due_results.push_back(e);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        faults++;
      end
    endfunction

    // Check one result word against the oldest prediction
    function void check_result(res_t got);
      res_t e;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0h", $time, got);
        faults++;
      end else begin
        e = due_results.pop_front();
        compare_field("data", e.data, got.data);
        compare_field("found_at", DATA_W'(e.found_at), DATA_W'(got.found_at));
        compare_field("status", DATA_W'(e.status), DATA_W'(got.status));
        compare_field("entries", DATA_W'(e.entries), DATA_W'(got.entries));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // position[7:0], value[39:8]
  logic [2:0]  s_axis_tuser = '0;   // operation[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // data[31:0], found_at[40:32], entries[49:41]
  logic [0:0]  m_axis_tuser;        // status[0]

  list_mirror mirror = new();
  int   send_idle_pct = 9;
  int   recv_idle_pct = 76;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   cycle_count = 0;
  res_t seen_res;

  bounded_array_list_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side ready: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_res.data     = m_axis_tdata[31:0];
      seen_res.found_at = m_axis_tdata[40:32];
      seen_res.entries  = m_axis_tdata[49:41];
      seen_res.status   = m_axis_tuser[0];
      mirror.check_result(seen_res);
    end
  end

  // Offer one request word, wait for the handshake, note it
  task automatic send_request(input req_t r);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.val, r.pos};
    s_axis_tuser  <= r.op;
    do @(posedge clk); while (!s_axis_tready);
    mirror.take_request(r);
  endtask

  task automatic send_fields(input op_t op, input int pos, input logic [31:0] val);
    req_t r;
    r.op  = op;
    r.pos = pos[POS_W-1:0];
    r.val = val;
    send_request(r);
  endtask

  // Mostly a small pool so finds and removes hit, plus extremes and noise
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3, 4: return $urandom;
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  task automatic send_random_item();
    req_t r;
    int   pick;
    int   n;
    int   p;
    n    = mirror.held;
    pick = $urandom_range(0, 99);
    if (pick < 20) r.op = OP_APPEND;
    else if (pick < 40) r.op = OP_INSERT;
    else if (pick < 55) r.op = OP_PREPEND;
    else if (pick < 63) r.op = OP_POP;
    else if (pick < 75) r.op = OP_READ;
    else if (pick < 85) r.op = OP_FIND;
    else if (pick < 95) r.op = OP_DELETE;
    else r.op = OP_REMOVE;
    r.val = pick_value();
    // searches mostly target a value that is held
    if ((r.op == OP_FIND || r.op == OP_REMOVE) && n > 0 && $urandom_range(0, 99) < 60)
      r.val = mirror.cells[$urandom_range(0, n - 1)];
    if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 255);
    else p = $urandom_range(0, n + 1);
    r.pos = (p > 255) ? 8'd255 : p[7:0];
    send_request(r);
  endtask

  // Stop offering and wait until every result is in and the core is idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [8:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mirror.cap_reg = v;
    @(posedge clk);
  endtask

  function automatic logic [8:0] phase_capacity(input int ph);
    case (ph)
      0: return 9'd8;
      1: return 9'd40;
      2: return 9'd3;
      3: return 9'd0;
      4: return 9'd1;
      5: return 9'd256;
      6: return 9'd511;
      7: return 9'd16;
      default: return 9'd2;
    endcase
  endfunction

  // Edge cases on an empty and a short list
  task automatic run_directed();
    send_fields(OP_POP, 0, 32'h0);            // empty pop
    send_fields(OP_READ, 0, 32'h0);           // read on empty
    send_fields(OP_FIND, 0, 32'h0);           // find on empty
    send_fields(OP_REMOVE, 0, 32'h0);         // remove on empty
    send_fields(OP_DELETE, 0, 32'h0);         // delete on empty
    send_fields(OP_INSERT, 1, 32'h1234_5678); // insert past the end
    send_fields(OP_INSERT, 0, 32'h8000_0000);
    send_fields(OP_APPEND, 0, 32'h7FFF_FFFF);
    send_fields(OP_PREPEND, 0, 32'hFFFF_FFFF);
    send_fields(OP_INSERT, 3, 32'd5);         // insert at count acts as append
    send_fields(OP_INSERT, 5, 32'd9);         // one past count
    send_fields(OP_INSERT, 1, 32'd5);
    send_fields(OP_READ, 0, 32'h0);
    send_fields(OP_READ, 4, 32'h0);
    send_fields(OP_READ, 5, 32'h0);
    send_fields(OP_READ, 255, 32'hFFFF_FFFF);
    send_fields(OP_FIND, 0, 32'd5);
    send_fields(OP_FIND, 0, 32'd1234);
    send_fields(OP_DELETE, 0, 32'h0);
    send_fields(OP_DELETE, 255, 32'h0);
    send_fields(OP_REMOVE, 0, 32'd5);         // two matches
    send_fields(OP_REMOVE, 0, 32'd5);         // no match left
    send_fields(OP_POP, 0, 32'h0);
    send_fields(OP_POP, 0, 32'h0);
    send_fields(OP_POP, 0, 32'h0);
  endtask

  // Main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      if (ph == 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 9;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(phase_capacity(ph));
      // long result stall while requests keep coming
      if (ph == 1) hold_seq <= hold_seq + 1;
      // fill the whole store, then knock on the full list
      if (phase_capacity(ph) == 9'd256) begin
        while (mirror.held < STORE_DEPTH) send_fields(OP_APPEND, 0, pick_value());
        send_fields(OP_APPEND, 0, 32'd1);
        send_fields(OP_PREPEND, 0, 32'd2);
        send_fields(OP_INSERT, 0, 32'd3);
      end
      repeat (PHASE_ITEMS) send_random_item();
    end
    s_axis_tvalid <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mirror.faults == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
